>>> hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants for the tilt fall detector
// Widths, register indexes, direction codes, reset values and the
// per-tick classification record passed from the compare logic to the tracker.
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam int AngleW = 16;
	localparam int LimitW = 14;
	localparam int CountW = 16;
	localparam int DirW   = 3;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_ROLL_LIMIT   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_PITCH_LIMIT  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WAKEUP_TICKS = 2'd2;

	// fall direction codes
	localparam logic [DirW-1:0] DIR_NONE     = 3'd0;
	localparam logic [DirW-1:0] DIR_LEFT     = 3'd1;
	localparam logic [DirW-1:0] DIR_RIGHT    = 3'd2;
	localparam logic [DirW-1:0] DIR_BACKWARD = 3'd3;
	localparam logic [DirW-1:0] DIR_FORWARD  = 3'd4;

	localparam logic [LimitW-1:0] ROLL_LIMIT_RST   = 14'd3200;
	localparam logic [LimitW-1:0] PITCH_LIMIT_RST  = 14'd3520;
	localparam logic [CountW-1:0] WAKEUP_TICKS_RST = 16'd50;
	localparam logic [CountW-1:0] COUNT_MAX        = 16'hFFFF;

	typedef struct packed {
		logic            over;   // a magnitude strictly above its limit
		logic            hit;    // tilt at or beyond a limit: count this tick
		logic [DirW-1:0] dir;    // direction of the hit
		logic            clear;  // both magnitudes below half limit
	} tilt_class_t;

endpackage

>>> hdl/tfd_classify.sv
// ----------------------------------------------------------------------------
// tfd_classify: tilt compare logic
// Compares one roll/pitch sample against the limits and reports whether the
// tick counts toward a fall, in which direction, or whether it recovers.
// ----------------------------------------------------------------------------
module tfd_classify (
	input  logic signed [tfd_pkg::AngleW-1:0] roll_angle,
	input  logic signed [tfd_pkg::AngleW-1:0] pitch_angle,
	input  logic        [tfd_pkg::LimitW-1:0] roll_limit,
	input  logic        [tfd_pkg::LimitW-1:0] pitch_limit,
	output tfd_pkg::tilt_class_t              cls
);

	localparam int WideW = tfd_pkg::AngleW + 1;

	logic signed [WideW-1:0] roll_x, pitch_x;
	logic signed [WideW-1:0] rl_pos, rl_neg, pl_pos, pl_neg;
	logic        [WideW-1:0] rmag, pmag;
	logic        [WideW:0]   rmag2, pmag2;
	logic roll_hi, roll_lo, pitch_hi, pitch_lo;

	always_comb begin
		roll_x  = WideW'(roll_angle);
		pitch_x = WideW'(pitch_angle);
		rl_pos  = signed'(WideW'(roll_limit));
		pl_pos  = signed'(WideW'(pitch_limit));
		rl_neg  = -rl_pos;
		pl_neg  = -pl_pos;
		// 17-bit magnitude keeps the most negative angle exact
		rmag    = roll_x[WideW-1] ? unsigned'(-roll_x) : unsigned'(roll_x);
		pmag    = pitch_x[WideW-1] ? unsigned'(-pitch_x) : unsigned'(pitch_x);
		rmag2   = {rmag, 1'b0};
		pmag2   = {pmag, 1'b0};

		roll_hi  = roll_x >= rl_pos;
		roll_lo  = roll_x <= rl_neg;
		pitch_hi = pitch_x >= pl_pos;
		pitch_lo = pitch_x <= pl_neg;

		cls.over  = (rmag > WideW'(roll_limit)) || (pmag > WideW'(pitch_limit));
		cls.hit   = roll_hi || roll_lo || pitch_hi || pitch_lo;
		cls.clear = (rmag2 < (WideW+1)'(roll_limit)) && (pmag2 < (WideW+1)'(pitch_limit));

		// roll takes priority over pitch
		if (roll_hi) begin
			cls.dir = tfd_pkg::DIR_LEFT;
		end else if (roll_lo) begin
			cls.dir = tfd_pkg::DIR_RIGHT;
		end else if (pitch_hi) begin
			cls.dir = tfd_pkg::DIR_BACKWARD;
		end else begin
			cls.dir = tfd_pkg::DIR_FORWARD;
		end
	end

endmodule

>>> hdl/tfd_track.sv
// ----------------------------------------------------------------------------
// tfd_track: tick counter, direction latch and result register
// Advances the saturating tick counter, latches the fall direction past the
// wake-up count, clears on recovery and holds the result for the output side.
// ----------------------------------------------------------------------------
module tfd_track (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              out_ready,
	input  tfd_pkg::tilt_class_t              cls,
	input  logic        [tfd_pkg::CountW-1:0] wakeup_ticks,
	output logic                              out_valid,
	output logic        [tfd_pkg::DirW-1:0]   fall_direction,
	output logic                              over_limit,
	output logic                              recovered
);

	logic [tfd_pkg::CountW-1:0] count_q, count_d;
	logic [tfd_pkg::DirW-1:0]   dir_q, dir_d;
	logic                       rec_d;

	always_comb begin
		count_d = count_q;
		dir_d   = dir_q;
		rec_d   = 1'b0;
		if (cls.hit) begin
			if (count_q != tfd_pkg::COUNT_MAX) begin
				count_d = count_q + 1'b1;
			end
			if (count_d > wakeup_ticks) begin
				dir_d = cls.dir;
			end
		end else if (cls.clear) begin
			count_d = '0;
			dir_d   = tfd_pkg::DIR_NONE;
			rec_d   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dir_q     <= tfd_pkg::DIR_NONE;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				count_q   <= count_d;
				dir_q     <= dir_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload, loaded with each advancing request
	always_ff @(posedge clk) begin
		if (en) begin
			fall_direction <= dir_d;
			over_limit     <= cls.over;
			recovered      <= rec_d;
		end
	end

endmodule

>>> hdl/tilt_fall_detector_top.sv
// Path: an accepted sample is held in the input register, then moves to the result register
// once that register is free or being drained, where it waits for out_ready.
// Throughput: one sample per cycle; the input register takes a new request while a
// result waits, and the pipe stalls only when both stages are full and out_ready is low.
// Reset: arst_n clears the tick counter, the fall direction and both valid flags, and
// loads the limit registers with 3200, 3520 and a wake-up count of 50.
// ----------------------------------------------------------------------------
// tilt_fall_detector_top: tilt fall detector
// Configuration registers, input register and handshake around the compare
// logic and the fall tracker.
// ----------------------------------------------------------------------------
module tilt_fall_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic        [tfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic        [tfd_pkg::CfgDataW-1:0] cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tfd_pkg::AngleW-1:0]   roll_angle,
	input  logic signed [tfd_pkg::AngleW-1:0]   pitch_angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [tfd_pkg::DirW-1:0]     fall_direction,
	output logic                                over_limit,
	output logic                                recovered
);

	logic [tfd_pkg::LimitW-1:0] roll_limit_q, pitch_limit_q;
	logic [tfd_pkg::CountW-1:0] wakeup_q;

	logic                              valid_s1;
	logic signed [tfd_pkg::AngleW-1:0] roll_s1, pitch_s1;
	logic                              advance;
	tfd_pkg::tilt_class_t              cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_limit_q  <= tfd_pkg::ROLL_LIMIT_RST;
			pitch_limit_q <= tfd_pkg::PITCH_LIMIT_RST;
			wakeup_q      <= tfd_pkg::WAKEUP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfd_pkg::CFG_ROLL_LIMIT:   roll_limit_q  <= cfg_data[tfd_pkg::LimitW-1:0];
				tfd_pkg::CFG_PITCH_LIMIT:  pitch_limit_q <= cfg_data[tfd_pkg::LimitW-1:0];
				tfd_pkg::CFG_WAKEUP_TICKS: wakeup_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// move stage 1 into the result register when it is free or being drained
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			roll_s1  <= roll_angle;
			pitch_s1 <= pitch_angle;
		end
	end

	tfd_classify u_classify (
		.roll_angle  (roll_s1),
		.pitch_angle (pitch_s1),
		.roll_limit  (roll_limit_q),
		.pitch_limit (pitch_limit_q),
		.cls         (cls)
	);

	tfd_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (valid_s1 && advance),
		.out_ready      (out_ready),
		.cls            (cls),
		.wakeup_ticks   (wakeup_q),
		.out_valid      (out_valid),
		.fall_direction (fall_direction),
		.over_limit     (over_limit),
		.recovered      (recovered)
	);

endmodule

>>> tb/tilt_fall_detector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_fall_detector_top_tb: self-checking bench for the tilt fall detector
// Feeds roll/pitch samples through valid/ready with bursty input and a
// stalling output, predicts direction, over-limit and recovered per sample
// and compares every result in order. Covers several limit and wake-up
// settings, zero and large (11520) limits, extreme angles and fall episodes.
// ----------------------------------------------------------------------------
module tilt_fall_detector_top_tb;

	localparam int ItemsPerPhase = 155;
	localparam int NumPhases     = 8;
	localparam int HoldCycles    = 300;
	localparam int CycleLimit    = 400000;

	// roll, pitch pairs around the reset limits of 3200 and 3520
	localparam int DIRECTED [13][2] = '{
		'{0, 0}, '{3200, 0}, '{3199, 0}, '{3201, 0}, '{-3200, 0}, '{-3201, 0},
		'{0, 3520}, '{0, 3521}, '{0, -3520}, '{1600, 1760}, '{1599, 1759},
		'{-32768, -32768}, '{32767, 32767}
	};

	typedef struct packed {
		logic signed [tfd_pkg::AngleW-1:0] roll;
		logic signed [tfd_pkg::AngleW-1:0] pitch;
	} tilt_sample_t;

	typedef struct packed {
		logic [tfd_pkg::DirW-1:0] dir;
		logic                     over;
		logic                     rec;
	} fall_result_t;

	typedef enum int {AK_CALM, AK_BAND, AK_EDGE, AK_PAST, AK_ANY} angle_kind_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_we = 1'b0;
	logic [tfd_pkg::CfgIdxW-1:0]        cfg_index = '0;
	logic [tfd_pkg::CfgDataW-1:0]       cfg_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [tfd_pkg::AngleW-1:0]  roll_angle = '0;
	logic signed [tfd_pkg::AngleW-1:0]  pitch_angle = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [tfd_pkg::DirW-1:0]           fall_direction;
	logic                               over_limit;
	logic                               recovered;

	// predictor state and its copy of the registers
	logic [tfd_pkg::LimitW-1:0] roll_lim = tfd_pkg::ROLL_LIMIT_RST;
	logic [tfd_pkg::LimitW-1:0] pitch_lim = tfd_pkg::PITCH_LIMIT_RST;
	logic [tfd_pkg::CountW-1:0] wake_ticks = tfd_pkg::WAKEUP_TICKS_RST;
	logic [tfd_pkg::CountW-1:0] tick_count = '0;
	logic [tfd_pkg::DirW-1:0]   fall_dir = tfd_pkg::DIR_NONE;

	tilt_sample_t samples_q[$];
	fall_result_t expected_falls[$];
	int unsigned  queued_items = 0;
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	bit           req_taken = 1'b0;
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           stall_mode = 0;
	int           mode_left = 0;

	tilt_fall_detector_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.roll_angle     (roll_angle),
		.pitch_angle    (pitch_angle),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.fall_direction (fall_direction),
		.over_limit     (over_limit),
		.recovered      (recovered)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [tfd_pkg::AngleW-1:0] to_angle(int v);
		return v[tfd_pkg::AngleW-1:0];
	endfunction

	function automatic void count_tilt_tick(logic [tfd_pkg::DirW-1:0] dir);
		if (tick_count != tfd_pkg::COUNT_MAX)
			tick_count++;
		if (tick_count > wake_ticks)
			fall_dir = dir;
	endfunction

	function automatic fall_result_t step_fall_tracker(
			logic signed [tfd_pkg::AngleW-1:0] roll,
			logic signed [tfd_pkg::AngleW-1:0] pitch);
		int r, p, rl, pl, rm, pm;
		fall_result_t res;
		r = int'(roll);
		p = int'(pitch);
		rl = int'(roll_lim);
		pl = int'(pitch_lim);
		rm = (r < 0) ? -r : r;
		pm = (p < 0) ? -p : p;
		res.over = (rm > rl) || (pm > pl);
		res.rec = 1'b0;
		if (r >= rl) begin
			count_tilt_tick(tfd_pkg::DIR_LEFT);
		end else if (r <= -rl) begin
			count_tilt_tick(tfd_pkg::DIR_RIGHT);
		end else if (p >= pl) begin
			count_tilt_tick(tfd_pkg::DIR_BACKWARD);
		end else if (p <= -pl) begin
			count_tilt_tick(tfd_pkg::DIR_FORWARD);
		end else if (2 * rm < rl && 2 * pm < pl) begin
			fall_dir = tfd_pkg::DIR_NONE;
			tick_count = '0;
			res.rec = 1'b1;
		end
		res.dir = fall_dir;
		return res;
	endfunction

	function automatic logic signed [tfd_pkg::AngleW-1:0] pick_angle(angle_kind_t kind,
			int lim);
		int v;
		case (kind)
			AK_CALM: v = (lim > 0) ? int'($urandom_range((lim - 1) / 2, 0)) : 0;
			AK_BAND: v = (lim > 1) ? int'($urandom_range((lim + 1) / 2, lim - 1)) : lim;
			AK_EDGE: v = lim + int'($urandom_range(0, 2)) - 1;
			AK_PAST: v = int'($urandom_range(lim, 32768));
			default: begin
				v = int'($urandom);
				return v[tfd_pkg::AngleW-1:0];
			end
		endcase
		if (v < 0)
			v = 0;
		if ($urandom_range(0, 1))
			v = -v;
		if (v > 32767)
			v = 32767;
		return v[tfd_pkg::AngleW-1:0];
	endfunction

	// angle at or past the limit on the chosen side
	function automatic logic signed [tfd_pkg::AngleW-1:0] tilt_past(int lim, bit neg);
		int v;
		v = int'($urandom_range(lim, neg ? 32768 : 32767));
		if (neg)
			v = -v;
		return v[tfd_pkg::AngleW-1:0];
	endfunction

	task automatic add_sample(logic signed [tfd_pkg::AngleW-1:0] roll,
			logic signed [tfd_pkg::AngleW-1:0] pitch);
		tilt_sample_t s;
		s.roll = roll;
		s.pitch = pitch;
		samples_q.push_back(s);
		queued_items++;
	endtask

	function automatic angle_kind_t any_kind(angle_kind_t hi);
		return angle_kind_t'($urandom_range(AK_CALM, hi));
	endfunction

	// tilt past a limit for the wake-up count plus up to six samples (20 to 60 when that exceeds 60), then settle back
	task automatic add_fall_episode();
		int len;
		int pick;
		logic [tfd_pkg::DirW-1:0] dir;
		logic signed [tfd_pkg::AngleW-1:0] r, p;
		pick = int'($urandom_range(tfd_pkg::DIR_LEFT, tfd_pkg::DIR_FORWARD));
		dir = pick[tfd_pkg::DirW-1:0];
		len = int'(wake_ticks) + int'($urandom_range(0, 6));
		if (len > 60)
			len = int'($urandom_range(20, 60));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				pick = int'($urandom_range(tfd_pkg::DIR_LEFT, tfd_pkg::DIR_FORWARD));
				dir = pick[tfd_pkg::DirW-1:0];
			end
			r = pick_angle(any_kind(AK_EDGE), int'(roll_lim));
			p = pick_angle(any_kind(AK_PAST), int'(pitch_lim));
			case (dir)
				tfd_pkg::DIR_LEFT:     r = tilt_past(int'(roll_lim), 1'b0);
				tfd_pkg::DIR_RIGHT:    r = tilt_past(int'(roll_lim), 1'b1);
				tfd_pkg::DIR_BACKWARD: p = tilt_past(int'(pitch_lim), 1'b0);
				default:               p = tilt_past(int'(pitch_lim), 1'b1);
			endcase
			add_sample(r, p);
		end
		repeat ($urandom_range(0, 3))
			add_sample(pick_angle(any_kind(AK_BAND), int'(roll_lim)),
				pick_angle(any_kind(AK_BAND), int'(pitch_lim)));
		repeat ($urandom_range(1, 3))
			add_sample(pick_angle(AK_CALM, int'(roll_lim)),
				pick_angle(AK_CALM, int'(pitch_lim)));
	endtask

	task automatic write_reg(logic [tfd_pkg::CfgIdxW-1:0] idx,
			logic [tfd_pkg::CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tfd_pkg::CFG_ROLL_LIMIT:   roll_lim = val[tfd_pkg::LimitW-1:0];
			tfd_pkg::CFG_PITCH_LIMIT:  pitch_lim = val[tfd_pkg::LimitW-1:0];
			tfd_pkg::CFG_WAKEUP_TICKS: wake_ticks = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (samples_q.size() != 0 || in_valid || expected_falls.size() != 0)
			@(posedge clk);
	endtask

	// sender: bursts of requests with random gaps between them
	always @(negedge clk) begin
		tilt_sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (samples_q.size() != 0) begin
				s = samples_q.pop_front();
				roll_angle <= s.roll;
				pitch_angle <= s.pitch;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changes at random intervals; long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HoldCycles;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	always @(posedge clk) begin
		fall_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_falls.size() == 0) begin
					$display("%0t: result with no request pending: dir %0d over %0b rec %0b",
						$time, fall_direction, over_limit, recovered);
					mismatches++;
				end else begin
					want = expected_falls.pop_front();
					if (fall_direction !== want.dir) begin
						$display("%0t: fall_direction expected %0d actual %0d",
							$time, want.dir, fall_direction);
						mismatches++;
					end
					if (over_limit !== want.over) begin
						$display("%0t: over_limit expected %0b actual %0b",
							$time, want.over, over_limit);
						mismatches++;
					end
					if (recovered !== want.rec) begin
						$display("%0t: recovered expected %0b actual %0b",
							$time, want.rec, recovered);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_falls.push_back(step_fall_tracker(roll_angle, pitch_angle));
				req_taken = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("tilt_fall_detector_top: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned base;
		int rl, pl, wk;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k])
			add_sample(to_angle(DIRECTED[k][0]), to_angle(DIRECTED[k][1]));
		wait_idle();
		write_reg(tfd_pkg::CFG_WAKEUP_TICKS, 16'd1);
		foreach (DIRECTED[k])
			add_sample(to_angle(DIRECTED[k][0]), to_angle(DIRECTED[k][1]));

		for (int ph = 0; ph < NumPhases; ph++) begin
			wait_idle();
			case (ph)
				0: begin rl = 3200;  pl = 3520;  wk = 50;    end
				1: begin rl = 0;     pl = 0;     wk = 0;     end
				2: begin rl = 11520; pl = 11520; wk = 65534; end
				3: begin rl = 11520; pl = 0;     wk = 5;     end
				4: begin rl = 1;     pl = 1;     wk = 1;     end
				default: begin
					rl = $urandom_range(0, 11520);
					pl = $urandom_range(0, 11520);
					wk = $urandom_range(0, 12);
				end
			endcase
			write_reg(tfd_pkg::CFG_ROLL_LIMIT, rl[tfd_pkg::CfgDataW-1:0]);
			write_reg(tfd_pkg::CFG_PITCH_LIMIT, pl[tfd_pkg::CfgDataW-1:0]);
			write_reg(tfd_pkg::CFG_WAKEUP_TICKS, wk[tfd_pkg::CfgDataW-1:0]);
			// back up the output while the sender keeps offering
			if (ph == 0)
				hold_req = 1'b1;
			base = queued_items;
			while (queued_items - base < ItemsPerPhase) begin
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 4))
						add_sample(pick_angle(any_kind(AK_ANY), rl),
							pick_angle(any_kind(AK_ANY), pl));
				end else begin
					add_fall_episode();
				end
			end
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tilt_fall_detector_top: match");
		else
			$display("tilt_fall_detector_top: mismatch");
		$finish;
	end

endmodule
